// ===== hdl/csoc_pkg.sv =====
`timescale 1ns / 1ps

package csoc_pkg;

    // Default geometry
    localparam int CsocColumns = 240;
    localparam int CsocRows    = 160;

    // Width of the signed working values: 16-bit lines plus headroom
    localparam int YW = 18;

    // Command codes; code 3 is unused and ignored
    localparam logic [1:0] CmdClear  = 2'd0;
    localparam logic [1:0] CmdWall   = 2'd1;
    localparam logic [1:0] CmdPortal = 2'd2;

    typedef logic signed [YW-1:0] t_ys;

    typedef struct packed {
        logic [7:0]  start;
        logic [7:0]  stop;
        logic [15:0] color;
    } t_span;

    function automatic t_ys smax(input t_ys a, input t_ys b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_ys smin(input t_ys a, input t_ys b);
        return (a < b) ? a : b;
    endfunction

endpackage

// ===== hdl/csoc_bound_mem.sv =====
`timescale 1ns / 1ps

module csoc_bound_mem #(
    parameter int COLUMNS = 240,
    parameter int ROWS    = 160,
    parameter int AW      = 8,
    parameter int BW      = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clear,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [BW-1:0] i_wr_top,
    input  logic [BW-1:0] i_wr_bot,
    output logic [BW-1:0] o_rd_top,
    output logic [BW-1:0] o_rd_bot
);

    logic [2*BW-1:0] r_mem [COLUMNS];
    logic [COLUMNS-1:0] r_valid;
    logic [2*BW-1:0] r_rd_data;
    logic            r_rd_valid;

    // Storage: write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_top, i_wr_bot};
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Entry valid bits: an invalid entry reads as the open window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_top = r_rd_valid ? r_rd_data[2*BW-1:BW] : '0;
    assign o_rd_bot = r_rd_valid ? r_rd_data[BW-1:0]    : BW'(ROWS);

endmodule

// ===== hdl/csoc_span_calc.sv =====
`timescale 1ns / 1ps

module csoc_span_calc #(
    parameter int ROWS = 160,
    parameter int BW   = 8
) (
    input  logic                 i_portal,
    input  logic [BW-1:0]        i_top,
    input  logic [BW-1:0]        i_bot,
    input  logic signed [15:0]   i_y0,
    input  logic signed [15:0]   i_y1,
    input  logic signed [15:0]   i_y2,
    input  logic signed [15:0]   i_y3,
    input  logic [15:0]          i_ceiling_color,
    input  logic [15:0]          i_wall_color,
    input  logic [15:0]          i_ground_color,
    output csoc_pkg::t_span      o_spans [4],
    output logic [3:0]           o_mask,
    output logic                 o_open,
    output logic [BW-1:0]        o_new_top,
    output logic [BW-1:0]        o_new_bot
);

    import csoc_pkg::*;

    localparam t_ys RowsS = YW'(ROWS);

    t_ys t, b, y0, y1, y2, y3, a, z, nt, nb;
    t_ys s [4];
    t_ys e [4];

    always_comb begin
        t  = YW'(i_top);
        b  = YW'(i_bot);
        y0 = YW'(i_y0);
        y1 = YW'(i_y1);
        y2 = YW'(i_y2);
        y3 = YW'(i_y3);
        a  = smax('0, y0);
        z  = smin(RowsS, y3);
        if (i_portal) begin
            s[0] = t;             e[0] = smin(y0, b);
            s[1] = smax(y0, t);   e[1] = smin(y1, b);
            s[2] = smax(y2, t);   e[2] = smin(y3, b);
            s[3] = smax(y3, t);   e[3] = b;
            nt = smax(t, smin(y1, RowsS));
            nb = smax('0, smin(b, y2));
        end else begin
            s[0] = t;             e[0] = smin(a, b);
            s[1] = smax(a, t);    e[1] = smin(z, b);
            s[2] = smax(z, t);    e[2] = b;
            s[3] = '0;            e[3] = '0;
            nt = b;
            nb = b;
        end
    end

    assign o_open    = (i_top < i_bot);
    assign o_new_top = nt[BW-1:0];
    assign o_new_bot = nb[BW-1:0];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            o_mask[k]         = o_open && (e[k] > s[k]);
            o_spans[k].start  = s[k][7:0];
            o_spans[k].stop   = e[k][7:0];
        end
        o_mask[3] = o_mask[3] && i_portal;
        o_spans[0].color = i_ceiling_color;
        o_spans[1].color = i_wall_color;
        o_spans[2].color = i_portal ? i_wall_color : i_ground_color;
        o_spans[3].color = i_ground_color;
    end

endmodule

// ===== hdl/column_span_occlusion_clipper.sv =====
`timescale 1ns / 1ps

// Channel   | Direction | Signals                                      | Handshake
// ----------+-----------+----------------------------------------------+-------------------------
// request   | in        | i_command, i_column, i_*_y, i_*_color        | start high, busy low
// span      | out       | o_span_column/start/end/color, o_last        | o_span_strobe, one cycle
// config    | in        | i_cfg_data (ceiling colour)                  | i_cfg_valid & o_cfg_ready
//
// A wall or portal request reads the bound memory, then clips and writes back, then
// emits its spans (0 to 4 of them) one after another.
// Clear, unused commands and columns beyond the screen leave the block idle.
// Clear drops the per-column valid bits at once, so no sweep follows reset or clear.
// Spans cannot be stalled: each sits on the ports for exactly one cycle.

module column_span_occlusion_clipper #(
    parameter int COLUMNS = csoc_pkg::CsocColumns,
    parameter int ROWS    = csoc_pkg::CsocRows
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_command,
    input  logic [7:0]         i_column,
    input  logic signed [15:0] i_top_line_y,
    input  logic signed [15:0] i_inner_top_y,
    input  logic signed [15:0] i_inner_bottom_y,
    input  logic signed [15:0] i_bottom_line_y,
    input  logic [15:0]        i_wall_color,
    input  logic [15:0]        i_ground_color,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data,
    output logic               o_span_strobe,
    output logic [7:0]         o_span_column,
    output logic [7:0]         o_span_start,
    output logic [7:0]         o_span_end,
    output logic [15:0]        o_span_color,
    output logic               o_last
);

    import csoc_pkg::*;

    localparam int AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int BW = $clog2(ROWS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]  r_state, n_state;
    logic [3:0]  r_mask, n_mask;
    logic [15:0] r_ceiling_color;

    // Held request payload
    logic               r_portal;
    logic [7:0]         r_column;
    logic signed [15:0] r_y0, r_y1, r_y2, r_y3;
    logic [15:0]        r_wall_color, r_ground_color;

    // Clipped spans of the current request
    t_span r_spans [4];

    // Output registers
    logic        r_strobe, n_strobe;
    logic        r_last, n_last;
    logic [7:0]  r_out_start, r_out_stop;
    logic [15:0] r_out_color;

    logic        accept, col_ok, draw_cmd, do_clear, do_read, do_write;
    logic [BW-1:0] rd_top, rd_bot, new_top, new_bot;
    t_span       calc_spans [4];
    logic [3:0]  calc_mask;
    logic        calc_open;
    logic [1:0]  pick;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign col_ok      = ({24'd0, i_column} < 32'(COLUMNS));
    assign draw_cmd    = (i_command == CmdWall) || (i_command == CmdPortal);
    assign do_clear    = accept && (i_command == CmdClear);
    assign do_read     = accept && draw_cmd && col_ok;
    assign do_write    = (r_state == S_CALC) && calc_open;

    csoc_bound_mem #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .AW      (AW),
        .BW      (BW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (do_clear),
        .i_rd_en   (do_read),
        .i_rd_addr (AW'(i_column)),
        .i_wr_en   (do_write),
        .i_wr_addr (AW'(r_column)),
        .i_wr_top  (new_top),
        .i_wr_bot  (new_bot),
        .o_rd_top  (rd_top),
        .o_rd_bot  (rd_bot)
    );

    csoc_span_calc #(
        .ROWS (ROWS),
        .BW   (BW)
    ) u_calc (
        .i_portal        (r_portal),
        .i_top           (rd_top),
        .i_bot           (rd_bot),
        .i_y0            (r_y0),
        .i_y1            (r_y1),
        .i_y2            (r_y2),
        .i_y3            (r_y3),
        .i_ceiling_color (r_ceiling_color),
        .i_wall_color    (r_wall_color),
        .i_ground_color  (r_ground_color),
        .o_spans         (calc_spans),
        .o_mask          (calc_mask),
        .o_open          (calc_open),
        .o_new_top       (new_top),
        .o_new_bot       (new_bot)
    );

    // Lowest pending span goes out first: spans run top to bottom
    always_comb begin
        if (r_mask[0]) begin
            pick = 2'd0;
        end else if (r_mask[1]) begin
            pick = 2'd1;
        end else if (r_mask[2]) begin
            pick = 2'd2;
        end else begin
            pick = 2'd3;
        end
    end

    // Sequencer: read, clip and write back, then emit spans
    always_comb begin
        n_state  = r_state;
        n_mask   = r_mask;
        n_strobe = 1'b0;
        n_last   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (do_read) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_mask  = calc_mask;
                n_state = (calc_mask != 4'd0) ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                n_mask    = r_mask & ~(4'd1 << pick);
                n_strobe  = 1'b1;
                n_last    = (n_mask == 4'd0);
                if (n_mask == 4'd0) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_mask  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_mask          <= '0;
            r_strobe        <= 1'b0;
            r_last          <= 1'b0;
            r_ceiling_color <= '0;
        end else begin
            r_state  <= n_state;
            r_mask   <= n_mask;
            r_strobe <= n_strobe;
            r_last   <= n_last;
            if (i_cfg_valid && o_cfg_ready) begin
                r_ceiling_color <= i_cfg_data;
            end
        end
    end

    // Payload: hold the request, latch clipped spans, advance the output
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_portal       <= (i_command == CmdPortal);
            r_column       <= i_column;
            r_y0           <= i_top_line_y;
            r_y1           <= i_inner_top_y;
            r_y2           <= i_inner_bottom_y;
            r_y3           <= i_bottom_line_y;
            r_wall_color   <= i_wall_color;
            r_ground_color <= i_ground_color;
        end
        if (r_state == S_CALC) begin
            r_spans <= calc_spans;
        end
        if (r_state == S_EMIT) begin
            r_out_start <= r_spans[pick].start;
            r_out_stop  <= r_spans[pick].stop;
            r_out_color <= r_spans[pick].color;
        end
    end

    assign o_span_strobe = r_strobe;
    assign o_span_column = r_column;
    assign o_span_start  = r_out_start;
    assign o_span_end    = r_out_stop;
    assign o_span_color  = r_out_color;
    assign o_last        = r_last;

    // Spans come only from the emit state
    a_strobe_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_span_strobe |-> $past(r_state) == S_EMIT)
        else $error("span strobe without emit state");

    // Spans of one request leave on consecutive cycles until the last
    a_spans_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_span_strobe && !o_last) |=> o_span_strobe)
        else $error("gap inside a span group");

    // An idle block has nothing pending
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_mask == 4'd0))
        else $error("pending spans while idle");

    // A drawable request always moves on to the clip cycle
    a_read_then_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_read |=> (r_state == S_CALC))
        else $error("accepted column not clipped");

endmodule
